@@ sv/mme_pkg.sv @@
// ----------------------------------------------------------------------------
// mme_pkg
// shared widths, codes and control types of the matrix multiply engine
// ----------------------------------------------------------------------------
package mme_pkg;

  // payload widths of the request and response beats
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 6;
  localparam int VALUE_W = 16;
  localparam int ACC_W   = 40;

  // configuration port
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE_A = 2'd0,
    MODE_WRITE_B = 2'd1,
    MODE_QUERY   = 2'd2
  } mode_t;

  // sequencer to multiply-accumulate unit
  typedef struct packed {
    logic clear;       // zero the accumulator
    logic term_valid;  // operand pair from the memories is valid
  } mac_ctrl_t;

endpackage

@@ sv/mme_req_if.sv @@
// ----------------------------------------------------------------------------
// mme_req_if
// request channel: element writes and product queries
// ----------------------------------------------------------------------------
interface mme_req_if;
  logic                               valid;
  logic                               ready;
  logic [mme_pkg::MODE_W-1:0]         mode;
  logic [mme_pkg::IDX_W-1:0]          row;
  logic [mme_pkg::IDX_W-1:0]          col;
  logic signed [mme_pkg::VALUE_W-1:0] value;

  modport source (output valid, mode, row, col, value, input ready);
  modport sink (input valid, mode, row, col, value, output ready);
endinterface

@@ sv/mme_rsp_if.sv @@
// ----------------------------------------------------------------------------
// mme_rsp_if
// response channel: one beat per request
// ----------------------------------------------------------------------------
interface mme_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [mme_pkg::ACC_W-1:0] product;
  logic                             index_error;

  modport source (output valid, product, index_error, input ready);
  modport sink (input valid, product, index_error, output ready);
endinterface

@@ sv/matrix_multiply_engine.sv @@
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// fixed-point matrix product engine over two on-chip element memories
// ----------------------------------------------------------------------------
// usage
//   req beats carry mode, row, col and value. mode write_a / write_b stores a
//   Q4.12 element of A or B at (row, col); mode query returns element (row,col)
//   of C = A x B as a Q16.24 sum of inner_dim terms; any other mode is a no-op
//   every req beat produces exactly one rsp beat (product, index_error);
//   an index outside the configured dimensions gives index_error with product 0
//   and a rejected write leaves the memories untouched
// timing
//   writes, errors and empty sums: the rsp beat is registered from the req beat itself
//   queries: the rsp beat follows the sum, which passes the memory read, product
//   and accumulator registers at one multiply-accumulate per cycle through a
//   shared multiplier fed by one read port on each memory
//   the block takes a new req beat once the previous one has finished, so a
//   query holds off the next beat for its whole sum
// reset and stalls
//   rst clears the sequencer and output valid and sets all three dimension
//   registers to 64; memory contents are undefined until written
//   one result can wait in the output register while the next beat is taken;
//   a second finished result is parked and req.ready drops until rsp drains
// write configuration only while no request is in flight
// ----------------------------------------------------------------------------
module matrix_multiply_engine #(
  parameter int MAX_DIM    = 64,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mme_pkg::CFG_W-1:0]         cfg_data,
  mme_req_if.sink                           req,
  mme_rsp_if.source                         rsp
);

  // index bits per dimension, address bits per memory
  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW = 2 * IW;
  // width that holds a port index and a memory index
  localparam int XW = (IW > mme_pkg::IDX_W) ? IW : mme_pkg::IDX_W;
  // width for dimension compares and the term counter (holds MAX_DIM)
  localparam int CW = (IW + 1 > mme_pkg::CFG_W) ? IW + 1 : mme_pkg::CFG_W;
  localparam int RW = mme_pkg::ACC_W;

  localparam logic [CW-1:0] DIM_LIM = CW'(MAX_DIM);
  // element saturation bounds
  localparam logic signed [32:0] E_HI = 33'((64'sd1 <<< (ELEM_WIDTH - 1)) - 64'sd1);
  localparam logic signed [32:0] E_LO = -E_HI - 33'sd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_t;

  state_t state;

  // dimension registers
  logic [mme_pkg::CFG_W-1:0] rows_a;
  logic [mme_pkg::CFG_W-1:0] inner_dim;
  logic [mme_pkg::CFG_W-1:0] cols_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= mme_pkg::DIM_RESET;
      inner_dim <= mme_pkg::DIM_RESET;
      cols_b    <= mme_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mme_pkg::REG_ROWS_A:    rows_a    <= cfg_data;
        mme_pkg::REG_INNER_DIM: inner_dim <= cfg_data;
        mme_pkg::REG_COLS_B:    cols_b    <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective dimensions, clipped to the memory size
  logic [CW-1:0] ra_e, kd_e, cb_e;

  always_comb begin
    ra_e = (CW'(rows_a)    > DIM_LIM) ? DIM_LIM : CW'(rows_a);
    kd_e = (CW'(inner_dim) > DIM_LIM) ? DIM_LIM : CW'(inner_dim);
    cb_e = (CW'(cols_b)    > DIM_LIM) ? DIM_LIM : CW'(cols_b);
  end

  // request decode
  logic          fire;
  logic [CW-1:0] row_c, col_c;
  logic [XW-1:0] row_x, col_x;
  logic [IW-1:0] row_idx, col_idx;
  logic          a_ok, b_ok, q_ok;
  logic          is_wa, is_wb, is_q;
  logic          start_run;

  logic signed [32:0]         v_ext, v_sat;
  logic [ELEM_WIDTH-1:0]      wdata;
  logic [AW-1:0]              waddr;
  logic                       we_a, we_b;

  assign req.ready = (state == S_IDLE);
  assign fire      = req.valid && req.ready;

  always_comb begin
    row_c   = CW'(req.row);
    col_c   = CW'(req.col);
    row_x   = XW'(req.row);
    col_x   = XW'(req.col);
    row_idx = row_x[IW-1:0];
    col_idx = col_x[IW-1:0];
    is_wa   = (req.mode == mme_pkg::MODE_WRITE_A);
    is_wb   = (req.mode == mme_pkg::MODE_WRITE_B);
    is_q    = (req.mode == mme_pkg::MODE_QUERY);
    a_ok    = (row_c < ra_e) && (col_c < kd_e);
    b_ok    = (row_c < kd_e) && (col_c < cb_e);
    q_ok    = (row_c < ra_e) && (col_c < cb_e);
    start_run = fire && is_q && q_ok && (kd_e != '0);
    we_a    = fire && is_wa && a_ok;
    we_b    = fire && is_wb && b_ok;
    waddr   = {row_idx, col_idx};
    // saturate the incoming element to the stored width
    v_ext   = 33'(req.value);
    if (v_ext > E_HI) begin
      v_sat = E_HI;
    end else if (v_ext < E_LO) begin
      v_sat = E_LO;
    end else begin
      v_sat = v_ext;
    end
    wdata   = v_sat[ELEM_WIDTH-1:0];
  end

  // query sequencing: one term address per cycle into both memories
  logic [IW-1:0] q_row, q_col;
  logic [CW-1:0] kd_q;
  logic [CW-1:0] issue_cnt;
  logic [IW-1:0] k_idx;
  logic          issuing;
  logic          rd_valid;
  logic [AW-1:0] raddr_a, raddr_b;
  logic [ELEM_WIDTH-1:0] rdata_a, rdata_b;

  always_comb begin
    k_idx   = issue_cnt[IW-1:0];
    issuing = (state == S_RUN) && (issue_cnt < kd_q);
    raddr_a = {q_row, k_idx};
    raddr_b = {k_idx, q_col};
  end

  // writes happen only in idle and read data is used only during a query, so
  // no used read meets a write in the same cycle
  mme_ram #(
    .DATA_W (ELEM_WIDTH),
    .ADDR_W (AW)
  ) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mme_ram #(
    .DATA_W (ELEM_WIDTH),
    .ADDR_W (AW)
  ) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  mme_pkg::mac_ctrl_t        mac_ctrl;
  logic                      mac_busy;
  logic signed [RW-1:0]      mac_acc;

  always_comb begin
    mac_ctrl.clear      = fire;
    mac_ctrl.term_valid = rd_valid;
  end

  mme_mac #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .a    (rdata_a),
    .b    (rdata_b),
    .busy (mac_busy),
    .acc  (mac_acc)
  );

  // result of the current item, valid for one cycle
  logic                 fin;
  logic signed [RW-1:0] fin_product;
  logic                 fin_error;
  logic                 run_done;
  logic                 out_free;

  always_comb begin
    run_done    = (state == S_RUN) && !issuing && !rd_valid && !mac_busy;
    fin         = 1'b0;
    fin_product = '0;
    fin_error   = 1'b0;
    if (fire && !start_run) begin
      fin       = 1'b1;
      fin_error = (is_wa && !a_ok) || (is_wb && !b_ok) || (is_q && !q_ok);
    end else if (run_done) begin
      fin         = 1'b1;
      fin_product = mac_acc;
    end
    out_free = !rsp.valid || rsp.ready;
  end

  // parked result when the output register is still occupied
  logic signed [RW-1:0] hold_product;
  logic                 hold_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issue_cnt <= '0;
      rd_valid  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      rd_valid <= issuing;
      case (state)
        S_IDLE: begin
          if (start_run) begin
            state     <= S_RUN;
            issue_cnt <= '0;
            q_row     <= row_idx;
            q_col     <= col_idx;
            kd_q      <= kd_e;
          end else if (fin && !out_free) begin
            state <= S_HOLD;
          end
        end
        S_RUN: begin
          if (issuing) begin
            issue_cnt <= issue_cnt + CW'(1);
          end
          if (fin) begin
            state <= out_free ? S_IDLE : S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (fin) begin
        hold_product <= fin_product;
        hold_error   <= fin_error;
      end

      if (fin && out_free) begin
        rsp.valid       <= 1'b1;
        rsp.product     <= fin_product;
        rsp.index_error <= fin_error;
      end else if ((state == S_HOLD) && out_free) begin
        rsp.valid       <= 1'b1;
        rsp.product     <= hold_product;
        rsp.index_error <= hold_error;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/mme_ram.sv @@
// ----------------------------------------------------------------------------
// mme_ram
// single-port-write, single-port-read memory with registered read data
// ----------------------------------------------------------------------------
module mme_ram #(
  parameter int DATA_W = 16,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/mme_mac.sv @@
// ----------------------------------------------------------------------------
// mme_mac
// registered multiplier followed by a saturating 40-bit accumulator
// ----------------------------------------------------------------------------
module mme_mac #(
  parameter int ELEM_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mme_pkg::mac_ctrl_t               ctrl,
  input  logic signed [ELEM_WIDTH-1:0]     a,
  input  logic signed [ELEM_WIDTH-1:0]     b,
  output logic                             busy,
  output logic signed [mme_pkg::ACC_W-1:0] acc
);

  localparam int PW = 2 * ELEM_WIDTH;
  localparam int SW = ((PW > mme_pkg::ACC_W) ? PW : mme_pkg::ACC_W) + 1;
  localparam int AW = mme_pkg::ACC_W;

  logic signed [PW-1:0] prod;
  logic                 prod_valid;
  logic signed [SW-1:0] sum;
  logic [SW-AW:0]       sum_top;
  logic signed [AW-1:0] acc_next;

  always_comb begin
    sum     = SW'(acc) + SW'(prod);
    sum_top = sum[SW-1:AW-1];
    if ((&sum_top) || !(|sum_top)) begin
      acc_next = sum[AW-1:0];
    end else if (sum[SW-1]) begin
      acc_next = {1'b1, {(AW-1){1'b0}}};
    end else begin
      acc_next = {1'b0, {(AW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.term_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc_next;
    end
  end

  assign busy = prod_valid;

endmodule

@@ bench/mme_checker.sv @@
// ----------------------------------------------------------------------------
// mme_checker
// watches the request, response and configuration ports of the matrix
// multiply engine, predicts every response beat and compares it in order
// ----------------------------------------------------------------------------
module mme_checker #(
  parameter int MAX_DIM    = 64,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mme_pkg::CFG_W-1:0]     cfg_data,
  mme_req_if                            req,
  mme_rsp_if                            rsp,
  output int                            failures,
  output int                            outstanding,
  output int                            queries_seen,
  output int                            index_errors
);
  timeunit 1ns;
  timeprecision 1ps;
  import mme_pkg::*;

  localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;

  typedef struct packed {
    logic signed [ACC_W-1:0] product;
    logic                    index_error;
  } rsp_beat_t;

  int               elem_a [MAX_DIM*MAX_DIM];
  int               elem_b [MAX_DIM*MAX_DIM];
  logic [CFG_W-1:0] dim_rows;
  logic [CFG_W-1:0] dim_inner;
  logic [CFG_W-1:0] dim_cols;
  rsp_beat_t        pending_results [$];

  initial begin
    failures     = 0;
    outstanding  = 0;
    queries_seen = 0;
    index_errors = 0;
    dim_rows     = DIM_RESET;
    dim_inner    = DIM_RESET;
    dim_cols     = DIM_RESET;
    foreach (elem_a[i]) elem_a[i] = 0;
    foreach (elem_b[i]) elem_b[i] = 0;
  end

  // oversized dimensions act as the full array
  function automatic int usable_dim(logic [CFG_W-1:0] d);
    return (int'(d) > MAX_DIM) ? MAX_DIM : int'(d);
  endfunction

  function automatic int fit_elem(logic signed [VALUE_W-1:0] v);
    longint hi;
    longint x;
    hi = (longint'(1) <<< (ELEM_WIDTH - 1)) - 1;
    x  = longint'(v);
    if (x > hi) x = hi;
    if (x < -hi - 1) x = -hi - 1;
    return int'(x);
  endfunction

  // applies one request to the element memories and forms its response
  function automatic rsp_beat_t dot_product(logic [MODE_W-1:0] m, logic [IDX_W-1:0] r,
                                            logic [IDX_W-1:0] c,
                                            logic signed [VALUE_W-1:0] v);
    rsp_beat_t res;
    longint    acc;
    int        nr;
    int        nk;
    int        nc;
    res = '0;
    acc = 0;
    nr  = usable_dim(dim_rows);
    nk  = usable_dim(dim_inner);
    nc  = usable_dim(dim_cols);
    case (m)
      MODE_WRITE_A: begin
        if (int'(r) < nr && int'(c) < nk) elem_a[int'(r)*MAX_DIM + int'(c)] = fit_elem(v);
        else res.index_error = 1'b1;
      end
      MODE_WRITE_B: begin
        if (int'(r) < nk && int'(c) < nc) elem_b[int'(r)*MAX_DIM + int'(c)] = fit_elem(v);
        else res.index_error = 1'b1;
      end
      MODE_QUERY: begin
        if (int'(r) < nr && int'(c) < nc) begin
          for (int k = 0; k < nk; k++) begin
            acc += longint'(elem_a[int'(r)*MAX_DIM + k]) * longint'(elem_b[k*MAX_DIM + int'(c)]);
            if (acc > ACC_HI) acc = ACC_HI;
            if (acc < ACC_LO) acc = ACC_LO;
          end
          res.product = acc[ACC_W-1:0];
        end else begin
          res.index_error = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_beat_t want;
    if (rst) begin
      dim_rows  = DIM_RESET;
      dim_inner = DIM_RESET;
      dim_cols  = DIM_RESET;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS_A:    dim_rows  = cfg_data;
          REG_INNER_DIM: dim_inner = cfg_data;
          REG_COLS_B:    dim_cols  = cfg_data;
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        if (req.mode == MODE_QUERY) queries_seen++;
        pending_results.push_back(dot_product(req.mode, req.row, req.col, req.value));
      end
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $error("response beat with nothing outstanding: product %0d, index_error %0b",
                 rsp.product, rsp.index_error);
          failures++;
        end else begin
          want = pending_results.pop_front();
          if (want.index_error) index_errors++;
          if (rsp.product !== want.product) begin
            $error("product mismatch: expected %0d, got %0d", want.product, rsp.product);
            failures++;
          end
          if (rsp.index_error !== want.index_error) begin
            $error("index_error mismatch: expected %0b, got %0b",
                   want.index_error, rsp.index_error);
            failures++;
          end
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

@@ bench/tb_matrix_multiply_engine.sv @@
// ----------------------------------------------------------------------------
// tb_matrix_multiply_engine
// drives element writes and product queries into the matrix multiply engine
// over a series of dimension settings, with random stalls on both channels;
// mme_checker predicts and compares every response beat
// ----------------------------------------------------------------------------
module tb_matrix_multiply_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import mme_pkg::*;

  localparam int              MAX_DIM     = 64;
  localparam int              ELEM_WIDTH  = 16;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;  // no-op mode, still answered
  localparam int              HOLD_CYCLES = 300;     // long response back-pressure
  localparam int              BIG_INNER   = 16;      // above this, aim queries at one cell

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  mme_req_if req_ch ();
  mme_rsp_if rsp_ch ();

  int failures;
  int outstanding;
  int queries_seen;
  int index_errors;

  // stimulus bookkeeping
  bit a_written [MAX_DIM][MAX_DIM];
  bit b_written [MAX_DIM][MAX_DIM];
  int use_rows  = MAX_DIM;
  int use_inner = MAX_DIM;
  int use_cols  = MAX_DIM;
  int send_idle_pct;
  int recv_idle_pct;
  int holds_asked;
  int holds_served;
  int items_sent;
  int settings_run;

  matrix_multiply_engine #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  mme_checker #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) result_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .failures     (failures),
    .outstanding  (outstanding),
    .queries_seen (queries_seen),
    .index_errors (index_errors)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hard stop in case the handshakes hang
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  // response side: random back-pressure, plus long hold-offs on request
  initial begin
    int hold_left;
    hold_left    = 0;
    holds_served = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_served < holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // idle profile: sender-light/receiver-heavy, the reverse, then none
  task automatic set_idle(int profile);
    case (profile)
      0: begin
        send_idle_pct = 30;
        recv_idle_pct = 79;
      end
      1: begin
        send_idle_pct = 79;
        recv_idle_pct = 30;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // every task below starts and ends just after a falling edge
  task automatic send_request(logic [MODE_W-1:0] m, int r, int c, int v);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode  <= m;
    req_ch.row   <= IDX_W'(r);
    req_ch.col   <= IDX_W'(c);
    req_ch.value <= VALUE_W'(v);
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    // track which memory cells hold data, so no query reads an unwritten one
    if (m == MODE_WRITE_A && r < use_rows && c < use_inner) a_written[r][c] = 1'b1;
    if (m == MODE_WRITE_B && r < use_inner && c < use_cols) b_written[r][c] = 1'b1;
    items_sent++;
  endtask

  // sender pause: nothing new until every response beat has come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(v);
    @(negedge clk);
  endtask

  // dimension registers change only with the engine idle
  task automatic set_dims(int ra, int kd, int cb);
    drain();
    write_reg(REG_ROWS_A, ra);
    write_reg(REG_INNER_DIM, kd);
    write_reg(REG_COLS_B, cb);
    cfg_we    <= 1'b0;
    use_rows  = (ra > MAX_DIM) ? MAX_DIM : ra;
    use_inner = (kd > MAX_DIM) ? MAX_DIM : kd;
    use_cols  = (cb > MAX_DIM) ? MAX_DIM : cb;
  endtask

  // mostly uniform, sometimes the Q4.12 extremes and values around zero
  function automatic int random_value();
    case ($urandom_range(15))
      0: return 32767;
      1: return -32768;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  // well-formed sequence: fill the A row and B column the query reads,
  // refreshing a few already written cells, then ask for the product
  task automatic fill_and_query(int r, int c);
    int qr;
    int qc;
    qr = r;
    qc = c;
    // with a long inner dimension every new cell costs two full vectors
    if (use_inner > BIG_INNER) begin
      qr = use_rows - 1;
      qc = use_cols - 1;
    end
    for (int k = 0; k < use_inner; k++) begin
      if (!a_written[qr][k] || $urandom_range(9) == 0)
        send_request(MODE_WRITE_A, qr, k, random_value());
      if (!b_written[k][qc] || $urandom_range(9) == 0)
        send_request(MODE_WRITE_B, k, qc, random_value());
    end
    send_request(MODE_QUERY, qr, qc, random_value());
  endtask

  task automatic random_item();
    int pick;
    int r;
    int c;
    pick = $urandom_range(99);
    r    = $urandom_range(MAX_DIM - 1);
    c    = $urandom_range(MAX_DIM - 1);
    if (pick < 8) begin
      // unused mode, any fields
      send_request(MODE_UNUSED, r, c, random_value());
    end else if (pick < 20) begin
      // write anywhere, often outside the configured shape
      send_request((pick < 14) ? MODE_WRITE_A : MODE_WRITE_B, r, c, random_value());
    end else if (pick < 30) begin
      // query anywhere
      if (r < use_rows && c < use_cols) fill_and_query(r, c);
      else send_request(MODE_QUERY, r, c, random_value());
    end else if (pick < 50 && use_rows > 0 && use_inner > 0) begin
      send_request(MODE_WRITE_A, $urandom_range(use_rows - 1), $urandom_range(use_inner - 1),
                   random_value());
    end else if (pick < 65 && use_inner > 0 && use_cols > 0) begin
      send_request(MODE_WRITE_B, $urandom_range(use_inner - 1), $urandom_range(use_cols - 1),
                   random_value());
    end else if (use_rows > 0 && use_cols > 0) begin
      fill_and_query($urandom_range(use_rows - 1), $urandom_range(use_cols - 1));
    end else begin
      // no valid cell exists in this shape
      send_request(MODE_QUERY, r, c, random_value());
    end
  endtask

  task automatic run_phase(int ra, int kd, int cb, int n, int profile, bit hold);
    int start;
    set_idle(profile);
    set_dims(ra, kd, cb);
    // ask for a long response stall while the sender keeps pushing
    if (hold) holds_asked++;
    start = items_sent;
    while (items_sent - start < n) random_item();
    settings_run++;
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    req_ch.valid  = 1'b0;
    req_ch.mode   = '0;
    req_ch.row    = '0;
    req_ch.col    = '0;
    req_ch.value  = '0;
    holds_asked   = 0;
    items_sent    = 0;
    settings_run  = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part on a 4x3 by 3x5 shape
    set_idle(0);
    set_dims(4, 3, 5);
    // extreme operands, mixed signs
    send_request(MODE_WRITE_A, 0, 0, 32767);
    send_request(MODE_WRITE_A, 0, 1, -32768);
    send_request(MODE_WRITE_A, 0, 2, 1);
    send_request(MODE_WRITE_B, 0, 0, 32767);
    send_request(MODE_WRITE_B, 1, 0, 32767);
    send_request(MODE_WRITE_B, 2, 0, -1);
    send_request(MODE_QUERY, 0, 0, 0);
    // largest positive sum: all terms -8.0 * -8.0, the Q4.12 minimum
    for (int k = 0; k < 3; k++) begin
      send_request(MODE_WRITE_A, 1, k, -32768);
      send_request(MODE_WRITE_B, k, 4, -32768);
    end
    send_request(MODE_QUERY, 1, 4, -1);
    // writes just outside each bound and at the far corner
    send_request(MODE_WRITE_A, 4, 0, 1234);
    send_request(MODE_WRITE_A, 0, 3, 1234);
    send_request(MODE_WRITE_B, 3, 0, -1234);
    send_request(MODE_WRITE_B, 0, 5, -1234);
    send_request(MODE_WRITE_A, 63, 63, 32767);
    // queries just outside each bound and at the far corner
    send_request(MODE_QUERY, 4, 0, 0);
    send_request(MODE_QUERY, 0, 5, 0);
    send_request(MODE_QUERY, 63, 63, 32767);
    // unused mode with all fields high
    send_request(MODE_UNUSED, 63, 63, -1);
    settings_run++;

    // random part: sender-light, receiver-heavy stalls first
    run_phase(4, 3, 5, 80, 0, 1'b0);
    run_phase(1, 1, 1, 40, 0, 1'b0);
    run_phase(64, 64, 64, 180, 0, 1'b0);
    // reversed stalls; no rows at all, then oversized rows/cols with empty sums
    run_phase(0, 5, 3, 30, 1, 1'b0);
    run_phase(100, 0, 127, 40, 1, 1'b0);
    run_phase(8, 6, 8, 100, 1, 1'b1);
    // no stalls
    run_phase(3, 16, 2, 60, 2, 1'b0);
    run_phase(64, 1, 64, 70, 2, 1'b0);

    drain();
    // room for any stray beat, about one full-length query
    repeat (MAX_DIM + 16) @(negedge clk);

    $display("covered %0d request beats over %0d dimension settings, incl. empty and oversized",
             items_sent, settings_run);
    $display("checked %0d queries and %0d index errors under random and long stalls",
             queries_seen, index_errors);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/mme_pkg.sv
sv/mme_req_if.sv
sv/mme_rsp_if.sv
sv/mme_ram.sv
sv/mme_mac.sv
sv/matrix_multiply_engine.sv
bench/mme_checker.sv
bench/tb_matrix_multiply_engine.sv
